### hw/rtl/idi_pkg.sv
// Shared types, constants and helper functions of the image differential invariants block.
`default_nettype none
package idi_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 12;
    localparam int SLOTS      = 6;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int DIM_BITS   = 11;
    localparam int MEM_DEPTH  = SLOTS * MAX_WIDTH;
    localparam int ADDR_BITS  = $clog2(MEM_DEPTH);
    localparam int AHEAD_BITS = DIM_BITS + 1;
    localparam int G_BITS     = PIXEL_BITS + 2;
    localparam int H_BITS     = PIXEL_BITS + 5;
    localparam int SQ_BITS    = 2 * G_BITS;
    localparam int PROD_BITS  = SQ_BITS + H_BITS;
    localparam int VALUE_BITS = 48;
    localparam int ACC_BITS   = VALUE_BITS + 2;
    localparam int IDX_BITS   = 2;

    localparam logic [IDX_BITS-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_LAPLACE,
        MODE_GRAD_SQ,
        MODE_NORMAL,
        MODE_TANGENT
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIFF,
        ST_CALC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [G_BITS-1:0] gx;
        logic signed [G_BITS-1:0] gy;
        logic signed [H_BITS-1:0] xx;
        logic signed [H_BITS-1:0] xy;
        logic signed [H_BITS-1:0] yy;
    } deriv_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] lo;
        logic [DIM_BITS-1:0] hi;
        logic                dbl;
    } pick_t;

    // Neighbor pair for a difference at index i of n; ends use the one-sided pair.
    function automatic pick_t pick(input logic [DIM_BITS-1:0] i, input logic [DIM_BITS-1:0] n);
        pick_t p;
        if (i == '0) begin
            p.lo  = '0;
            p.hi  = DIM_BITS'(1);
            p.dbl = 1'b1;
        end else if (i >= n - DIM_BITS'(1)) begin
            p.lo  = n - DIM_BITS'(2);
            p.hi  = n - DIM_BITS'(1);
            p.dbl = 1'b1;
        end else begin
            p.lo  = i - DIM_BITS'(1);
            p.hi  = i + DIM_BITS'(1);
            p.dbl = 1'b0;
        end
        return p;
    endfunction
endpackage
`default_nettype wire

### hw/rtl/idi_invariant.sv
// Shared-multiplier sequencer that forms the selected invariant from the derivatives.
`default_nettype none
module idi_invariant (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire idi_pkg::mode_t                    mode,
    input  wire idi_pkg::deriv_t                   deriv,
    output logic                                   done,
    output logic signed [idi_pkg::VALUE_BITS-1:0]  value
);
    import idi_pkg::*;

    localparam logic signed [ACC_BITS-1:0] VMAX = ACC_BITS'({1'b0, {(VALUE_BITS-1){1'b1}}});
    localparam logic signed [ACC_BITS-1:0] VMIN = -VMAX - ACC_BITS'(1);

    logic                        busy_reg;
    logic [2:0]                  step_reg;
    logic                        done_reg;
    logic signed [SQ_BITS-1:0]   sqx_reg, sqy_reg, cr_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [SQ_BITS-1:0]   a_op;
    logic signed [H_BITS-1:0]    b_op;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  sel;
    logic                        tangent;

    assign tangent = (mode == MODE_TANGENT);

    always_comb begin
        a_op = SQ_BITS'(deriv.gx);
        b_op = H_BITS'(deriv.gx);
        case (step_reg)
            3'd1: begin a_op = SQ_BITS'(deriv.gy); b_op = H_BITS'(deriv.gy); end
            3'd2: begin a_op = SQ_BITS'(deriv.gx); b_op = H_BITS'(deriv.gy); end
            3'd3: begin a_op = tangent ? sqy_reg : sqx_reg; b_op = deriv.xx; end
            3'd4: begin a_op = cr_reg; b_op = deriv.xy; end
            3'd5: begin a_op = tangent ? sqx_reg : sqy_reg; b_op = deriv.yy; end
            default: ;
        endcase
    end

    assign prod     = a_op * b_op;
    assign prod_ext = ACC_BITS'(prod_reg);

    always_comb begin
        case (mode)
            MODE_LAPLACE: sel = (ACC_BITS'(deriv.xx) + ACC_BITS'(deriv.yy)) <<< 2;
            MODE_GRAD_SQ: sel = (ACC_BITS'(sqx_reg) + ACC_BITS'(sqy_reg)) <<< 2;
            default:      sel = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            prod_reg <= prod;
            case (step_reg)
                3'd1: sqx_reg <= SQ_BITS'(prod_reg);
                3'd2: sqy_reg <= SQ_BITS'(prod_reg);
                3'd3: cr_reg  <= SQ_BITS'(prod_reg);
                3'd4: acc_reg <= prod_ext;
                3'd5: acc_reg <= tangent ? acc_reg - (prod_ext <<< 1)
                                         : acc_reg + (prod_ext <<< 1);
                3'd6: acc_reg <= acc_reg + prod_ext;
                3'd7: begin
                    if (sel > VMAX) begin
                        value_reg <= VALUE_BITS'(VMAX);
                    end else if (sel < VMIN) begin
                        value_reg <= VALUE_BITS'(VMIN);
                    end else begin
                        value_reg <= VALUE_BITS'(sel);
                    end
                end
                default: ;
            endcase
        end
    end

    assign done  = done_reg;
    assign value = value_reg;
endmodule
`default_nettype wire

### hw/rtl/image_differential_invariants.sv
// Top level: line memory, raster counters and fetch sequencer of the invariant engine.
//
//  channel  | direction | contents
//  s_       | in        | tdata: pixel[11:0]; tuser: drain
//  m_       | out       | tdata: value[47:0]; tlast: frame_end
//  cfg_     | in        | write enable, register index, write data
//
// A request that produces no result leaves the block idle. A request that produces a
// result runs through the accepting cycle, the sixteen reads of the line memory, the
// forming of the second derivatives, the eight steps of the shared multiplier and the
// load of the output register. Reset restores the state, configuration and raster counters
// and clears the output valid; the data registers and the line memory are not cleared.
// A finished result waits in the output register; the next request is taken
// while it waits, and only the following result stalls on it.
`default_nettype none
module image_differential_invariants (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,   // pixel
    input  wire logic [0:0]                         s_tuser,   // drain
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [idi_pkg::VALUE_BITS-1:0]          m_tdata,   // value
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [idi_pkg::IDX_BITS-1:0]       cfg_index,
    input  wire logic [idi_pkg::DIM_BITS-1:0]       cfg_wdata
);
    import idi_pkg::*;

    typedef struct packed {
        logic [DIM_BITS-1:0] row;
        logic [DIM_BITS-1:0] col;
        logic                dbl;
    } loc_t;

    function automatic loc_t locate(input logic [2:0] j, input logic hi_sel,
                                    input logic [DIM_BITS-1:0] r, input logic [DIM_BITS-1:0] c,
                                    input logic [DIM_BITS-1:0] ew,
                                    input logic [DIM_BITS-1:0] eh);
        pick_t pc, pr, p;
        loc_t l;
        logic gxf;
        logic [DIM_BITS-1:0] r0, c0;
        pc  = pick(c, ew);
        pr  = pick(r, eh);
        gxf = 1'b0;
        r0  = r;
        c0  = c;
        unique case (j)
            3'd0: gxf = 1'b1;
            3'd1: begin gxf = 1'b1; c0 = pc.hi; end
            3'd2: begin gxf = 1'b1; c0 = pc.lo; end
            3'd3: ;
            3'd4: c0 = pc.hi;
            3'd5: c0 = pc.lo;
            3'd6: r0 = pr.hi;
            default: r0 = pr.lo;
        endcase
        if (gxf) begin
            p     = pick(c0, ew);
            l.row = r0;
            l.col = hi_sel ? p.hi : p.lo;
        end else begin
            p     = pick(r0, eh);
            l.row = hi_sel ? p.hi : p.lo;
            l.col = c0;
        end
        l.dbl = p.dbl;
        return l;
    endfunction

    state_t state_reg, state_next;
    mode_t  mode_reg;
    logic [DIM_BITS-1:0]   width_reg, height_reg, ew, eh;
    logic [DIM_BITS-1:0]   in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic [SLOT_BITS-1:0]  in_slot_reg, out_slot_reg;
    logic [AHEAD_BITS-1:0] ahead_reg, ahead_inc;
    logic                  in_done_reg;
    logic [4:0]            step_reg;
    logic [3:0]            kk;
    logic [PIXEL_BITS-1:0] line_mem [MEM_DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg, lo_pix_reg, pixel;
    logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
    logic                  wr_en;
    logic signed [G_BITS-1:0] d_reg [8];
    logic signed [PIXEL_BITS:0] pdiff;
    loc_t                  rd_loc, done_loc;
    logic [DIM_BITS-1:0]   row_off;
    logic [3:0]            slot_sum;
    logic [SLOT_BITS-1:0]  rd_slot;
    logic                  accept, drain, start_emit, is_pixel, last, out_fire;
    pick_t                 pcc, prr;
    deriv_t                deriv_reg;
    logic                  calc_start_reg, calc_done;
    logic signed [VALUE_BITS-1:0] calc_value;
    logic                  m_valid_reg, m_last_reg;
    logic [VALUE_BITS-1:0] m_data_reg;

    assign ew = (width_reg < DIM_BITS'(2)) ? DIM_BITS'(2) :
                (width_reg > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_reg;
    assign eh = (height_reg < DIM_BITS'(2)) ? DIM_BITS'(2) : height_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign drain     = s_tuser[0];
    assign pixel     = s_tdata[PIXEL_BITS-1:0];
    assign is_pixel  = !in_done_reg && !drain;
    assign ahead_inc = ahead_reg + AHEAD_BITS'(1);
    assign start_emit = accept && (is_pixel
        ? (ahead_inc >= AHEAD_BITS'({ew, 1'b0}) + AHEAD_BITS'(3))
        : (in_done_reg && ahead_reg != '0));
    assign wr_en   = accept && is_pixel;
    assign wr_addr = ADDR_BITS'(in_slot_reg) * ADDR_BITS'(MAX_WIDTH)
                   + ADDR_BITS'(in_col_reg[COL_BITS-1:0]);

    // Read side: a row near the output row maps to its slot of the six-row ring.
    assign kk       = 4'(step_reg - 5'd1);
    assign rd_loc   = locate(step_reg[3:1], step_reg[0], out_row_reg, out_col_reg, ew, eh);
    assign done_loc = locate(kk[3:1], kk[0], out_row_reg, out_col_reg, ew, eh);
    assign row_off  = rd_loc.row - out_row_reg;
    assign slot_sum = 4'(out_slot_reg) + 4'd6 + row_off[3:0];
    assign rd_slot  = (slot_sum >= 4'd12) ? SLOT_BITS'(slot_sum - 4'd12) :
                      (slot_sum >= 4'd6)  ? SLOT_BITS'(slot_sum - 4'd6)  : SLOT_BITS'(slot_sum);
    assign rd_addr  = ADDR_BITS'(rd_slot) * ADDR_BITS'(MAX_WIDTH)
                    + ADDR_BITS'(rd_loc.col[COL_BITS-1:0]);
    assign pdiff    = $signed({1'b0, rd_data_reg}) - $signed({1'b0, lo_pix_reg});

    assign pcc = pick(out_col_reg, ew);
    assign prr = pick(out_row_reg, eh);

    assign last = (out_row_reg >= eh - DIM_BITS'(1)) && (out_col_reg >= ew - DIM_BITS'(1));
    assign out_fire = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= pixel;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start_emit) state_next = ST_FETCH;
            ST_FETCH: if (step_reg == 5'd16) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_CALC;
            ST_CALC:  if (calc_done) state_next = ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Fetch datapath: even reads give the low pixel, odd reads close a difference.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            step_reg <= step_reg + 5'd1;
            if (step_reg != 5'd0) begin
                if (!kk[0]) begin
                    lo_pix_reg <= rd_data_reg;
                end else begin
                    d_reg[kk[3:1]] <= done_loc.dbl ? (G_BITS'(pdiff) <<< 1) : G_BITS'(pdiff);
                end
            end
        end else begin
            step_reg <= '0;
        end
        if (state_reg == ST_DIFF) begin
            deriv_reg.gx <= d_reg[0];
            deriv_reg.gy <= d_reg[3];
            deriv_reg.xx <= pcc.dbl ? ((H_BITS'(d_reg[1]) - H_BITS'(d_reg[2])) <<< 1)
                                    : (H_BITS'(d_reg[1]) - H_BITS'(d_reg[2]));
            deriv_reg.xy <= pcc.dbl ? ((H_BITS'(d_reg[4]) - H_BITS'(d_reg[5])) <<< 1)
                                    : (H_BITS'(d_reg[4]) - H_BITS'(d_reg[5]));
            deriv_reg.yy <= prr.dbl ? ((H_BITS'(d_reg[6]) - H_BITS'(d_reg[7])) <<< 1)
                                    : (H_BITS'(d_reg[6]) - H_BITS'(d_reg[7]));
        end
        if (out_fire) begin
            m_data_reg <= calc_value;
            m_last_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calc_start_reg <= 1'b0;
        end else begin
            calc_start_reg <= (state_reg == ST_DIFF);
        end
    end

    idi_invariant u_inv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (calc_start_reg),
        .mode    (mode_reg),
        .deriv   (deriv_reg),
        .done    (calc_done),
        .value   (calc_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_LAPLACE;
            width_reg    <= DIM_BITS'(1024);
            height_reg   <= DIM_BITS'(1024);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            ahead_reg    <= '0;
            in_done_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                ahead_reg <= ahead_inc;
                if (in_col_reg + DIM_BITS'(1) >= ew) begin
                    in_col_reg  <= '0;
                    in_slot_reg <= (in_slot_reg == SLOT_BITS'(SLOTS - 1)) ? '0
                                 : in_slot_reg + SLOT_BITS'(1);
                    in_row_reg  <= in_row_reg + DIM_BITS'(1);
                    if (in_row_reg + DIM_BITS'(1) >= eh) begin
                        in_done_reg <= 1'b1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + DIM_BITS'(1);
                end
            end
            if (out_fire) begin
                ahead_reg <= ahead_reg - AHEAD_BITS'(1);
                if (last) begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                    ahead_reg    <= '0;
                    in_done_reg  <= 1'b0;
                end else if (out_col_reg + DIM_BITS'(1) >= ew) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + DIM_BITS'(1);
                    out_slot_reg <= (out_slot_reg == SLOT_BITS'(SLOTS - 1)) ? '0
                                  : out_slot_reg + SLOT_BITS'(1);
                end else begin
                    out_col_reg <= out_col_reg + DIM_BITS'(1);
                end
            end
            if (cfg_we) begin
                unique case (cfg_index) inside
                    REG_MODE: mode_reg <= mode_t'(cfg_wdata[1:0]);
                    REG_WIDTH, REG_HEIGHT: begin
                        if (cfg_index == REG_WIDTH) begin
                            width_reg <= cfg_wdata;
                        end else begin
                            height_reg <= cfg_wdata;
                        end
                        in_col_reg   <= '0;
                        in_row_reg   <= '0;
                        in_slot_reg  <= '0;
                        out_col_reg  <= '0;
                        out_row_reg  <= '0;
                        out_slot_reg <= '0;
                        ahead_reg    <= '0;
                        in_done_reg  <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
endmodule
`default_nettype wire

### hw/rtl/idi_checker.sv
// Port-level checker of the invariant block and its bind to the top level.
`default_nettype none
module idi_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic m_tlast
);
    // A result is loaded only from the compute path, which never takes a request.
    a_rise_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a compute pass");

    // The block only leaves idle on an accepted request.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input side went busy without a request");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_last_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tlast))
        else $error("frame end changed while stalled");
endmodule

bind image_differential_invariants idi_checker u_idi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
`default_nettype wire
